// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== rtl/eod_pkg.sv =====
// Package for the elevator order dispatcher: types, codes and sizes
`timescale 1ns / 1ps
package eod_pkg;
  localparam int NumFloorsDef = 4;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_NEXT  = 2'd1,
    OP_CLR   = 2'd2,
    OP_CLRAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_UP   = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_IN   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MOV_UP   = 2'd0,
    MOV_DOWN = 2'd1,
    MOV_STOP = 2'd2,
    MOV_RSV  = 2'd3
  } mov_t;

  // list selectors
  typedef enum logic [1:0] {
    LST_UP   = 2'd0,
    LST_DOWN = 2'd1,
    LST_STOP = 2'd2,
    LST_NONE = 2'd3
  } lst_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_UP,
    ST_ADD_DN,
    ST_CLR,
    ST_MOVE,
    ST_SORT,
    ST_NEAR,
    ST_PICK,
    ST_TAKE_RM,
    ST_TAKE_ADD,
    ST_DONE
  } state_t;
endpackage

// ===== rtl/elevator_order_dispatcher.sv =====
// Elevator order dispatcher: three floor lists and a target under a small sequencer
//
// One item is taken at a time; in_ready is low while it is worked on. A small
// sequencer walks the up, down and stop lists one entry per cycle through a
// shared compare unit, pausing while an entry is shifted out of a list.
// - Clear-all and ignored adds go straight to the done state.
// - An add scans the list for duplicates one entry per cycle, then appends.
// - A next-target while stopped or with no target sorts the stop buffer with
//   one compare-swap per cycle. With an empty buffer it scans both call
//   lists instead and takes the nearest call.
// - A floor clear sweeps all three lists and, on each match, shifts the rest
//   of that list down one slot per cycle.
// The result sits in an output register and is held until taken. in_ready
// returns in the cycle after the result transfer.
`timescale 1ns / 1ps
module elevator_order_dispatcher import eod_pkg::*; #(
  parameter int NUM_FLOORS = NumFloorsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [1:0]        in_order_kind,
  input  logic [1:0]        in_floor,
  input  logic [1:0]        in_movement,
  input  logic [2:0]        in_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [2:0] out_target
);
  localparam int IW = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
  localparam int CW = $clog2(NUM_FLOORS + 1);
  localparam int FW = 2;

  // list storage; entries beyond a count are never read
  logic [FW-1:0] lst_r [3][NUM_FLOORS];
  logic [CW-1:0] cnt_r [3];
  logic signed [2:0] tgt_r;

  state_t st_r, st_nxt;
  logic [1:0] op_r, kind_r, fl_r, mov_r;
  logic signed [4:0] pos_r;
  lst_t sel_r;
  logic [CW-1:0] k_r, pass_r;
  logic [CW-1:0] bu_idx_r, bd_idx_r;
  logic [3:0] bu_d_r, bd_d_r;
  logic bu_ok_r, bd_ok_r;
  logic [CW-1:0] rm_idx_r;
  logic [FW-1:0] take_f_r;
  logic out_valid_r;
  logic signed [2:0] out_tgt_r;

  assign in_ready = (st_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_target = out_tgt_r;

  // shared unit: current entry, its floor distance (half-floor gap halved) and move tests
  logic [FW-1:0] cur_f, nxt_f;
  logic signed [4:0] dlt;
  logic [3:0] hdist;
  logic [1:0] sidx;
  logic dup;
  always_comb begin
    sidx  = (sel_r == LST_NONE) ? 2'd0 : sel_r;
    cur_f = lst_r[sidx][k_r[IW-1:0]];
    nxt_f = lst_r[sidx][(k_r[IW-1:0] + IW'(1))];
    dlt   = $signed({2'b00, cur_f, 1'b0}) - pos_r;
    hdist = dlt[4] ? 4'((-dlt) >>> 1) : 4'(dlt >>> 1);
  end

  logic seq_hit;
  always_comb begin
    seq_hit = 1'b0;
    if (mov_r == MOV_UP)
      seq_hit = (pos_r < $signed({2'b00, cur_f, 1'b0})) &&
                (tgt_r > $signed({1'b0, cur_f}));
    else
      seq_hit = (pos_r > $signed({2'b00, cur_f, 1'b0})) &&
                (tgt_r < $signed({1'b0, cur_f}));
  end

  // duplicate search for add: one compare per cycle
  assign dup = (k_r < cnt_r[sidx]) && (cur_f == take_f_r);

  // decode the first state of an accepted item
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid && in_ready) begin
        unique case (in_op)
          OP_ADD: begin
            if (in_order_kind == KIND_NONE || 32'(in_floor) >= NUM_FLOORS)
              st_nxt = ST_DONE;
            else if (in_order_kind == KIND_DOWN) st_nxt = ST_ADD_DN;
            else st_nxt = ST_ADD_UP;
          end
          OP_NEXT: begin
            if ((in_movement == MOV_UP || in_movement == MOV_DOWN) && tgt_r >= 0)
              st_nxt = ST_MOVE;
            else st_nxt = ST_SORT;
          end
          OP_CLR:  st_nxt = ST_CLR;
          default: st_nxt = ST_DONE;
        endcase
      end
      default: st_nxt = st_r;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r[0] <= '0; cnt_r[1] <= '0; cnt_r[2] <= '0;
      tgt_r <= -3'sd1;
      out_valid_r <= 1'b0;
      sel_r <= LST_NONE;
      k_r <= '0;
    end else begin
      // raise the result on completion, drop it once transferred
      if (st_r == ST_DONE) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= in_op; kind_r <= in_order_kind; fl_r <= in_floor;
            mov_r <= in_movement; k_r <= '0; pass_r <= '0;
            take_f_r <= in_floor;
            st_r <= st_nxt;
            // nudge the position half a floor when moving with no target
            if (in_op == OP_NEXT && in_movement == MOV_UP && tgt_r < 0)
              pos_r <= $signed({2'b00, in_position}) + 5'sd1;
            else if (in_op == OP_NEXT && in_movement == MOV_DOWN && tgt_r < 0)
              pos_r <= $signed({2'b00, in_position}) - 5'sd1;
            else
              pos_r <= $signed({2'b00, in_position});
            if (in_op == OP_ADD)
              sel_r <= (in_order_kind == KIND_DOWN) ? LST_DOWN : LST_UP;
            else if (in_op == OP_CLR)
              sel_r <= LST_UP;
            else if (in_op == OP_NEXT) begin
              if (in_movement == MOV_UP && tgt_r >= 0) sel_r <= LST_UP;
              else if (in_movement == MOV_DOWN && tgt_r >= 0) sel_r <= LST_DOWN;
              else sel_r <= LST_STOP;
            end
            if (in_op == OP_CLRAL) begin
              cnt_r[0] <= '0; cnt_r[1] <= '0; cnt_r[2] <= '0;
              tgt_r <= -3'sd1;
            end
          end
        end
        // add: scan for duplicate, then append if absent and the list is not full
        ST_ADD_UP, ST_ADD_DN, ST_TAKE_ADD: begin
          if (dup || k_r >= cnt_r[sidx]) begin
            if (!dup && 32'(cnt_r[sidx]) < NUM_FLOORS) begin
              lst_r[sidx][cnt_r[sidx][IW-1:0]] <= take_f_r;
              cnt_r[sidx] <= cnt_r[sidx] + CW'(1);
            end
            if (st_r == ST_ADD_UP && kind_r == KIND_IN) begin
              k_r <= '0; sel_r <= LST_DOWN; st_r <= ST_ADD_DN;
            end else if (st_r == ST_TAKE_ADD) begin
              // resume the moving scan in the list taken from
              k_r <= rm_idx_r; sel_r <= (mov_r == MOV_UP) ? LST_UP : LST_DOWN;
              st_r <= (mov_r == MOV_UP || mov_r == MOV_DOWN) ? ST_MOVE : ST_DONE;
            end else begin
              k_r <= '0; st_r <= ST_DONE;
            end
          end else k_r <= k_r + CW'(1);
        end
        // clear floor: sweep each list, shifting out matches
        ST_CLR: begin
          if (k_r >= cnt_r[sidx]) begin
            k_r <= '0;
            if (sel_r == LST_STOP) begin
              if (tgt_r == $signed({1'b0, fl_r})) tgt_r <= -3'sd1;
              st_r <= ST_DONE;
            end else sel_r <= (sel_r == LST_UP) ? LST_DOWN : LST_STOP;
          end else if (cur_f == fl_r) begin
            rm_idx_r <= k_r; st_r <= ST_TAKE_RM; take_f_r <= fl_r;
          end else k_r <= k_r + CW'(1);
        end
        // moving with target: one call test per cycle
        ST_MOVE: begin
          if (k_r >= cnt_r[sidx]) st_r <= ST_DONE;
          else if (seq_hit) begin
            take_f_r <= cur_f; tgt_r <= $signed({1'b0, cur_f});
            rm_idx_r <= k_r; st_r <= ST_TAKE_RM;
          end else k_r <= k_r + CW'(1);
        end
        // bubble sort of stop buffer, one compare-swap per cycle; an empty buffer goes to the nearest call scan
        ST_SORT: begin
          if (cnt_r[2] == '0) begin
            k_r <= '0; sel_r <= LST_UP; bu_ok_r <= 1'b0; bd_ok_r <= 1'b0;
            st_r <= ST_NEAR;
          end else if (pass_r + CW'(1) >= cnt_r[2]) begin
            tgt_r <= $signed({1'b0, lst_r[2][0]});
            st_r <= ST_DONE;
          end else begin
            if (k_r + CW'(1) < cnt_r[2] - pass_r) begin
              if (cur_f > nxt_f) begin
                lst_r[2][k_r[IW-1:0]] <= nxt_f;
                lst_r[2][(k_r[IW-1:0] + IW'(1))] <= cur_f;
              end
              k_r <= k_r + CW'(1);
            end else begin
              k_r <= '0; pass_r <= pass_r + CW'(1);
            end
          end
        end
        // nearest call scan: up list then down list
        ST_NEAR: begin
          if (k_r >= cnt_r[sidx]) begin
            k_r <= '0;
            if (sel_r == LST_UP) sel_r <= LST_DOWN;
            else st_r <= ST_PICK;
          end else begin
            if (sel_r == LST_UP) begin
              if (!bu_ok_r || hdist < bu_d_r) begin
                bu_ok_r <= 1'b1; bu_d_r <= hdist; bu_idx_r <= k_r;
              end
            end else if (!bd_ok_r || hdist < bd_d_r) begin
              bd_ok_r <= 1'b1; bd_d_r <= hdist; bd_idx_r <= k_r;
            end
            k_r <= k_r + CW'(1);
          end
        end
        ST_PICK: begin
          if (!bu_ok_r && !bd_ok_r) begin
            st_r <= ST_DONE; op_r <= OP_CLRAL;
          end else begin
            if (bd_ok_r && (!bu_ok_r || bd_d_r < bu_d_r)) begin
              sel_r <= LST_DOWN; rm_idx_r <= bd_idx_r;
              take_f_r <= lst_r[1][bd_idx_r[IW-1:0]];
              tgt_r <= $signed({1'b0, lst_r[1][bd_idx_r[IW-1:0]]});
            end else begin
              sel_r <= LST_UP; rm_idx_r <= bu_idx_r;
              take_f_r <= lst_r[0][bu_idx_r[IW-1:0]];
              tgt_r <= $signed({1'b0, lst_r[0][bu_idx_r[IW-1:0]]});
            end
            mov_r <= MOV_STOP; k_r <= bu_idx_r;
            st_r <= ST_TAKE_RM;
          end
        end
        // remove entry rm_idx_r by shifting one slot per cycle
        ST_TAKE_RM: begin
          if (rm_idx_r + CW'(1) < cnt_r[sidx]) begin
            lst_r[sidx][rm_idx_r[IW-1:0]] <= lst_r[sidx][(rm_idx_r[IW-1:0] + IW'(1))];
            rm_idx_r <= rm_idx_r + CW'(1);
          end else begin
            cnt_r[sidx] <= cnt_r[sidx] - CW'(1);
            rm_idx_r <= k_r;
            if (op_r == OP_CLR) st_r <= ST_CLR;
            else begin
              sel_r <= LST_STOP; k_r <= '0; st_r <= ST_TAKE_ADD;
            end
          end
        end
        ST_DONE: begin
          out_tgt_r <= (op_r == OP_CLRAL) ? -3'sd1 : tgt_r;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/eod_checker.sv =====
// Port-level checker for the elevator order dispatcher, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eod_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [2:0] out_target
);
  `CHK_IMPLY(a_busy_when_full, clk, rst_n, out_valid, !in_ready)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_target))
  `CHK_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
  `CHK_IMPLY(a_target_range, clk, rst_n, out_valid, out_target >= -3'sd1)
endmodule

bind elevator_order_dispatcher eod_checker u_eod_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_target(out_target)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the elevator order dispatcher
`timescale 1ns / 1ps
module testbench;
  import eod_pkg::*;

  localparam int NumFloors = 4;
  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic [1:0] in_order_kind = '0;
  logic [1:0] in_floor = '0;
  logic [1:0] in_movement = '0;
  logic [2:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [2:0] out_target;

  elevator_order_dispatcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_order_kind(in_order_kind), .in_floor(in_floor),
    .in_movement(in_movement), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_target(out_target)
  );

  always #6 clk = ~clk;

  // Dispatcher shadow state
  logic [1:0] up_list[NumFloors];
  int up_n;
  logic [1:0] dn_list[NumFloors];
  int dn_n;
  logic [1:0] stops[NumFloors];
  int stop_n;
  int cur_target;

  logic signed [2:0] target_queue[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  bit stim_done = 1'b0;

  typedef struct {
    op_t op;
    kind_t kind;
    logic [1:0] flr;
    mov_t mov;
    logic [2:0] pos;
    int known;  // typed-in expected target, or 99 when predicted
  } order_row_t;

  function automatic void list_drop(ref logic [1:0] l[NumFloors], ref int n, input int idx);
    for (int k = idx; k + 1 < n; k++) l[k] = l[k + 1];
    n--;
  endfunction

  function automatic void list_put(ref logic [1:0] l[NumFloors], ref int n,
                                   input logic [1:0] f);
    for (int k = 0; k < n; k++) if (l[k] == f) return;
    if (n >= NumFloors) return;
    l[n] = f;
    n++;
  endfunction

  function automatic void list_purge(ref logic [1:0] l[NumFloors], ref int n,
                                     input logic [1:0] f);
    int k;
    k = 0;
    while (k < n) begin
      if (l[k] == f) list_drop(l, n, k);
      else k++;
    end
  endfunction

  function automatic int floor_gap(logic [1:0] f, int pos);
    int d;
    d = 2 * int'(f) - pos;
    if (d < 0) d = -d;
    return d / 2;
  endfunction

  // Pick from a standing start: lowest stop, else nearest call, up wins ties
  function automatic int pick_standing(int pos);
    int iu, idn, du, dd;
    logic [1:0] tmp, f;
    if (stop_n > 0) begin
      for (int a = 0; a + 1 < stop_n; a++)
        for (int b = 0; b + 1 < stop_n - a; b++)
          if (stops[b] > stops[b + 1]) begin
            tmp = stops[b];
            stops[b] = stops[b + 1];
            stops[b + 1] = tmp;
          end
      cur_target = stops[0];
      return cur_target;
    end
    iu = -1; idn = -1; du = 0; dd = 0;
    for (int k = 0; k < up_n; k++)
      if (iu < 0 || floor_gap(up_list[k], pos) < du) begin
        iu = k;
        du = floor_gap(up_list[k], pos);
      end
    for (int k = 0; k < dn_n; k++)
      if (idn < 0 || floor_gap(dn_list[k], pos) < dd) begin
        idn = k;
        dd = floor_gap(dn_list[k], pos);
      end
    if (iu < 0 && idn < 0) return -1;
    if (idn >= 0 && (iu < 0 || dd < du)) begin
      f = dn_list[idn];
      list_drop(dn_list, dn_n, idn);
    end else begin
      f = up_list[iu];
      list_drop(up_list, up_n, iu);
    end
    list_put(stops, stop_n, f);
    cur_target = f;
    return cur_target;
  endfunction

  function automatic int dispatch_target(logic [1:0] op, logic [1:0] kind, logic [1:0] f,
                                         logic [1:0] mov, logic [2:0] p);
    int pos, k;
    logic [1:0] c;
    pos = p;
    case (op)
      OP_ADD: begin
        if (kind == KIND_UP || kind == KIND_IN) list_put(up_list, up_n, f);
        if (kind == KIND_DOWN || kind == KIND_IN) list_put(dn_list, dn_n, f);
        return cur_target;
      end
      OP_NEXT: begin
        k = 0;
        if (mov == MOV_UP) begin
          if (cur_target < 0) return pick_standing(pos + 1);
          while (k < up_n) begin
            c = up_list[k];
            if (pos < 2 * int'(c) && cur_target > int'(c)) begin
              list_drop(up_list, up_n, k);
              list_put(stops, stop_n, c);
              cur_target = c;
            end else k++;
          end
          return cur_target;
        end
        if (mov == MOV_DOWN) begin
          if (cur_target < 0) return pick_standing(pos - 1);
          while (k < dn_n) begin
            c = dn_list[k];
            if (pos > 2 * int'(c) && cur_target < int'(c)) begin
              list_drop(dn_list, dn_n, k);
              list_put(stops, stop_n, c);
              cur_target = c;
            end else k++;
          end
          return cur_target;
        end
        return pick_standing(pos);
      end
      OP_CLR: begin
        list_purge(up_list, up_n, f);
        list_purge(dn_list, dn_n, f);
        list_purge(stops, stop_n, f);
        if (cur_target == int'(f)) cur_target = -1;
        return cur_target;
      end
      default: begin
        up_n = 0; dn_n = 0; stop_n = 0; cur_target = -1;
        return -1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Drive one order after an idle gap and hold it until transferred
  task automatic send_order(logic [1:0] op, logic [1:0] kind, logic [1:0] f,
                            logic [1:0] mov, logic [2:0] p, int known);
    int gap, tgt;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 2);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_op <= op; in_order_kind <= kind; in_floor <= f;
    in_movement <= mov; in_position <= p;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    tgt = dispatch_target(op, kind, f, mov, p);
    if (known != 99 && known != tgt)
      report_mismatch($sformatf("row value %0d disagrees with prediction %0d", known, tgt));
    target_queue.push_back(3'(tgt));
    sent++;
  endtask

  task automatic drain_results();
    while (target_queue.size() != 0) @(posedge clk);
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (target_queue.size() == 0) report_mismatch("result with nothing expected");
      else begin
        if (out_target !== target_queue[0])
          report_mismatch($sformatf("target got %0d want %0d", out_target,
                                    target_queue[0]));
        void'(target_queue.pop_front());
        checked++;
      end
    end
  end

  // Receiver stalls, with one long hold-off
  always @(posedge clk) begin
    if (long_hold && !hold_done) begin
      out_ready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_done <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(5, 30)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0) || stim_done;
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles", IdleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  order_row_t rows[] = '{
    '{OP_NEXT, KIND_UP, 2'd0, MOV_STOP, 3'd0, -1},
    '{OP_ADD, KIND_UP, 2'd3, MOV_UP, 3'd0, -1},
    '{OP_ADD, KIND_DOWN, 2'd0, MOV_UP, 3'd0, -1},
    '{OP_ADD, KIND_IN, 2'd2, MOV_UP, 3'd0, -1},
    '{OP_ADD, KIND_NONE, 2'd1, MOV_UP, 3'd0, -1},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_STOP, 3'd6, 99},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_UP, 3'd1, 99},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_RSV, 3'd3, 99},
    '{OP_CLR, KIND_UP, 2'd3, MOV_UP, 3'd0, 99},
    '{OP_CLRAL, KIND_UP, 2'd0, MOV_UP, 3'd0, -1},
    '{OP_ADD, KIND_DOWN, 2'd1, MOV_UP, 3'd0, -1},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_DOWN, 3'd0, 99},
    '{OP_ADD, KIND_DOWN, 2'd2, MOV_UP, 3'd0, 99},
    '{OP_ADD, KIND_UP, 2'd3, MOV_UP, 3'd0, 99},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_DOWN, 3'd6, 99},
    '{OP_CLRAL, KIND_UP, 2'd0, MOV_UP, 3'd0, -1},
    '{OP_ADD, KIND_UP, 2'd3, MOV_UP, 3'd0, -1},
    '{OP_ADD, KIND_UP, 2'd1, MOV_UP, 3'd0, -1},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_UP, 3'd7, 99},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_STOP, 3'd5, 99},
    '{OP_NEXT, KIND_UP, 2'd0, MOV_UP, 3'd0, 99},
    '{OP_CLR, KIND_UP, 2'd1, MOV_UP, 3'd0, 99},
    '{OP_CLRAL, KIND_IN, 2'd0, MOV_UP, 3'd0, -1}
  };

  initial begin
    logic [1:0] op, mov;
    int settle;
    up_n = 0; dn_n = 0; stop_n = 0; cur_target = -1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (rows[i])
      send_order(rows[i].op, rows[i].kind, rows[i].flr, rows[i].mov, rows[i].pos,
                 rows[i].known);

    // Random traffic: mostly adds and dispatches, occasional clears
    for (int n = 0; n < 1750; n++) begin
      if (n == 600) begin
        long_hold <= 1'b1;
        for (int j = 0; j < 8; j++)
          send_order(OP_ADD, 2'($urandom_range(0, 3)), 2'($urandom), 2'($urandom),
                     3'($urandom), 99);
        wait (hold_done);
      end
      if (n == 1200) drain_results();
      settle = $urandom_range(0, 99);
      if (settle < 45) op = OP_ADD;
      else if (settle < 85) op = OP_NEXT;
      else if (settle < 97) op = OP_CLR;
      else op = OP_CLRAL;
      mov = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 2));
      send_order(op, 2'($urandom_range(0, 3)), 2'($urandom), mov, 3'($urandom), 99);
    end
    stim_done <= 1'b1;

    drain_results();
    repeat (40) @(posedge clk);
    $display("Sent %0d orders and checked %0d targets over adds, dispatches and clears,",
             sent, checked);
    $display("including a long result stall and a full drain pause; %0d mismatches.", errors);
    if (errors == 0 && target_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
